[sv/mmvp_pkg.sv]
// ----------------------------------------------------------------------------
// mmvp_pkg
// Shared types and constants for the masked matrix-vector product block.
// ----------------------------------------------------------------------------
package mmvp_pkg;

  localparam int ROWS      = 16;
  localparam int COLS      = 256;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 8;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = ROWS * COLS;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int CNT_W     = 6;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes on the config port
  localparam logic [1:0] REG_DIVIDE_MODE = 2'd0;
  localparam logic [1:0] REG_MASK_ENABLE = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_ZERO_REPL   = 2'd3;

  // input opcodes
  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_e;

endpackage

[sv/masked_matrix_vector_product_top.sv]
// Per vector element each row runs READ, CALC and ACC states, with a DIV state
// between CALC and ACC in divide mode (48-step serial divider per row).
// Masked elements skip the row pass; a closing element then emits ROWS results,
// one per cycle when the sink is ready. One item is in work at a time.
// Reset: async active low; accumulators zero, registers to defaults,
// matrix memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
// masked_matrix_vector_product_top
// Stored matrix times streamed vector with masking, divide mode and a ring of
// accumulator cells that rotates once per row update and per emitted result.
// ----------------------------------------------------------------------------
module masked_matrix_vector_product_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_index[3:0], column_index[11:4], value[43:12], reference_value[75:44]
  input  logic [79:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_row[3:0], product_value[51:4]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import mmvp_pkg::*;

  // config registers
  logic        divide_mode_q, mask_enable_q;
  logic [30:0] thresh_q, zrep_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divide_mode_q <= 1'b0;
      mask_enable_q <= 1'b0;
      thresh_q      <= 31'h7FFF_FFFF;
      zrep_q        <= 31'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DIVIDE_MODE: divide_mode_q <= pwdata[0];
        REG_MASK_ENABLE: mask_enable_q <= pwdata[0];
        REG_THRESHOLD:   thresh_q      <= pwdata[30:0];
        REG_ZERO_REPL:   zrep_q        <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_DIVIDE_MODE: prdata = {31'd0, divide_mode_q};
      REG_MASK_ENABLE: prdata = {31'd0, mask_enable_q};
      REG_THRESHOLD:   prdata = {1'b0, thresh_q};
      REG_ZERO_REPL:   prdata = {1'b0, zrep_q};
      default:         prdata = '0;
    endcase
  end

  // input field split
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [DATA_W-1:0] in_val, in_ref;
  logic [DATA_W:0]   ref_mag;
  logic              counts, in_acc;

  assign in_row  = s_axis_tdata[3:0];
  assign in_col  = s_axis_tdata[11:4];
  assign in_val  = s_axis_tdata[43:12];
  assign in_ref  = s_axis_tdata[75:44];
  assign ref_mag = in_ref[DATA_W-1] ? (DATA_W+1)'(-$signed({in_ref[DATA_W-1], in_ref}))
                                    : {1'b0, in_ref};
  assign counts  = !mask_enable_q || (ref_mag < {2'b00, thresh_q});
  assign in_acc  = s_axis_tvalid & s_axis_tready;

  // sequencer state
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [DATA_W-1:0] val_q;
  logic              last_q, div_mode_q;
  logic              row_last, out_acc;
  logic              mem_rd, div_start, ring_shift;
  logic              div_done;

  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign out_acc  = m_axis_tvalid & m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser == OP_VECTOR) begin
          if (counts && (32'(in_col) < 32'(COLS))) begin
            state_d = ST_READ;
          end else if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = div_mode_q ? ST_DIV : ST_ACC;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (row_last) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_acc && row_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_rd        = (state_q == ST_READ);
    div_start     = (state_q == ST_CALC) && div_mode_q;
    m_axis_tvalid = (state_q == ST_EMIT);
    ring_shift    = (state_q == ST_ACC) || out_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      last_q     <= 1'b0;
      div_mode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        row_q      <= '0;
        last_q     <= s_axis_tlast;
        div_mode_q <= divide_mode_q;
      end else if (ring_shift) begin
        row_q <= row_last ? '0 : row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= in_col;
      val_q <= in_val;
    end
  end

  // matrix memory
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_wr;

  assign mem_wr = in_acc && (s_axis_tuser == OP_MATRIX)
                  && (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLS));

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[ADDR_W'({in_row, in_col})] <= in_val;
    end
    if (mem_rd) begin
      rdata_q <= mem_q[ADDR_W'({row_q, col_q})];
    end
  end

  // multiply path, registered product
  logic signed [2*DATA_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      prod_q <= $signed(rdata_q) * $signed(val_q);
    end
  end

  // divide path on magnitudes
  logic [DATA_W-1:0] m_mag, v_mag;
  logic [ACC_W-1:0]  dvd_mag, quot, div_term, mul_term, term;
  logic              div_neg;

  assign m_mag   = rdata_q[DATA_W-1] ? DATA_W'(-rdata_q) : rdata_q;
  assign v_mag   = val_q[DATA_W-1] ? DATA_W'(-val_q) : val_q;
  assign dvd_mag = {m_mag, 16'd0};
  assign div_neg = rdata_q[DATA_W-1] ^ val_q[DATA_W-1];

  mmvp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_mag),
    .divisor_i  (v_mag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // term selection with divide saturation
  always_comb begin
    if (val_q == '0) begin
      div_term = ACC_MAX;
    end else if (div_neg) begin
      div_term = ACC_W'(-quot);
    end else if (quot[ACC_W-1]) begin
      div_term = ACC_MAX;
    end else begin
      div_term = quot;
    end
    mul_term = prod_q[2*DATA_W-1:16];
    term     = div_mode_q ? div_term : mul_term;
  end

  // accumulator ring, cell 0 is the head
  logic [ACC_W-1:0] ring [ROWS];
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sat_sum, tail_d;

  always_comb begin
    sum = {ring[0][ACC_W-1], ring[0]} + {term[ACC_W-1], term};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_sum = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = sum[ACC_W-1:0];
    end
    tail_d = (state_q == ST_ACC) ? sat_sum : '0;
  end

  for (genvar k = 0; k < ROWS; k++) begin : g_cell
    logic [ACC_W-1:0] nbr;
    if (k == ROWS - 1) begin : g_tail
      assign nbr = tail_d;
    end else begin : g_mid
      assign nbr = ring[k+1];
    end
    mmvp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_shift),
      .acc_i   (nbr),
      .acc_o   (ring[k])
    );
  end

  // result transaction from the head cell
  logic [ACC_W-1:0] out_val;

  assign out_val      = (ring[0] == '0) ? ACC_W'(zrep_q) : ring[0];
  assign m_axis_tdata = {4'd0, out_val, row_q};
  assign m_axis_tlast = row_last;

endmodule

[sv/mmvp_div.sv]
// ----------------------------------------------------------------------------
// mmvp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmvp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mmvp_pkg::ACC_W-1:0]  dividend_i,
  input  logic [mmvp_pkg::DATA_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [mmvp_pkg::ACC_W-1:0]  quot_o
);
  import mmvp_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ACC_W-1:0]  dvd_q, dvd_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem_q, dvd_q[ACC_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DATA_W'(rem_sh - {1'b0, dvs_q}) : DATA_W'(rem_sh);
      dvd_d = {dvd_q[ACC_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ACC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

[sv/mmvp_cell.sv]
// ----------------------------------------------------------------------------
// mmvp_cell
// One accumulator cell of the rotating row ring.
// ----------------------------------------------------------------------------
module mmvp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [mmvp_pkg::ACC_W-1:0] acc_i,
  output logic [mmvp_pkg::ACC_W-1:0] acc_o
);
  import mmvp_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;

  // take the neighbor value on a ring step
  always_comb begin
    acc_d = shift_i ? acc_i : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
